/* rtl/vcunf_pkg.sv */
// Shared types and constants of the voxel column upper noise filter.
`default_nettype none

package vcunf_pkg;

   // Request commands.
   typedef enum logic [1:0] {
      CMD_CLEAR    = 2'd0,
      CMD_ADD      = 2'd1,
      CMD_BUILD    = 2'd2,
      CMD_CLASSIFY = 2'd3
   } command_type;

   // Response status codes.
   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
   localparam logic [1:0] STATUS_SAT     = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_ORIGIN_X        = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y        = 3'd1;
   localparam logic [2:0] CSR_ORIGIN_Z        = 3'd2;
   localparam logic [2:0] CSR_CELL_SIZE       = 3'd3;
   localparam logic [2:0] CSR_FILL_THRESHOLD  = 3'd4;
   localparam logic [2:0] CSR_VALID_THRESHOLD = 3'd5;
   localparam logic [2:0] CSR_MAX_GAP         = 3'd6;

   // Configuration reset values.
   localparam logic [23:0] RESET_CELL_SIZE       = 24'd5000;
   localparam logic [19:0] RESET_FILL_THRESHOLD  = 20'd1;
   localparam logic [19:0] RESET_VALID_THRESHOLD = 20'd5;
   localparam logic [23:0] RESET_MAX_GAP         = 24'd5000;

   // Sequencer states.
   typedef enum logic [12:0] {
      ST_CLEAR   = 13'b0000000000001,
      ST_IDLE    = 13'b0000000000010,
      ST_LOAD    = 13'b0000000000100,
      ST_DIV     = 13'b0000000001000,
      ST_ADDR    = 13'b0000000010000,
      ST_ADD_RD  = 13'b0000000100000,
      ST_ADD_WR  = 13'b0000001000000,
      ST_CLS_RD  = 13'b0000010000000,
      ST_CLS_MUL = 13'b0000100000000,
      ST_CLS_CMP = 13'b0001000000000,
      ST_BUILD   = 13'b0010000000000,
      ST_BWRITE  = 13'b0100000000000,
      ST_FINISH  = 13'b1000000000000
   } state_type;

endpackage

`default_nettype wire

/* rtl/voxel_column_upper_noise_filter_unit.sv */
// Top level of the voxel column upper noise filter: sequencer, divider and stores.
//
// Requests carry a command (clear, add point, build heights, classify point)
// and a point in millimetres. Every request yields exactly one response with
// keep and status. Both channels use valid and stall; a request is taken only
// while the sequencer is idle, so one request is worked on at a time, and the
// response register lets the next request start while a response still waits.
// Work per request:
//   add point: six axis divisions on the shared shift-subtract divider,
//   which makes QW = clog2(max(CELLS_X, CELLS_Y, CELLS_Z)) quotient bits,
//   one quotient bit per cycle.
//   classify: two divisions per grid.
//   build: one count read per cycle from each count memory, two passes per column.
//   clear: one memory entry zeroed per cycle.
// After reset the same clearing pass runs with req_stall high; configuration
// writes are taken during it.
// When rsp_stall is high the response holds, and a finished request waits in
// its last state until the response register is free.
`default_nettype none

module voxel_column_upper_noise_filter_unit import vcunf_pkg::*; #(
   parameter int CELLS_X    = 32,
   parameter int CELLS_Y    = 32,
   parameter int CELLS_Z    = 32,
   parameter int COUNT_BITS = 20
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Configuration port.
   input  wire logic                  csr_wr_en,
   input  wire logic [2:0]            csr_index,
   input  wire logic [31:0]           csr_wr_data,
   // Request channel.
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_command,
   input  wire logic signed [31:0]    req_point_x,
   input  wire logic signed [31:0]    req_point_y,
   input  wire logic signed [31:0]    req_point_z,
   // Response channel.
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_keep,
   output logic [1:0]                 rsp_status
);

   localparam int NUM_COLS  = CELLS_X * CELLS_Y;
   localparam int NUM_CELLS = NUM_COLS * CELLS_Z;
   localparam int CW        = $clog2(NUM_CELLS);
   localparam int LW        = $clog2(NUM_COLS);
   localparam int ZW        = $clog2(CELLS_Z);
   localparam int MAXC_XY   = (CELLS_X > CELLS_Y) ? CELLS_X : CELLS_Y;
   localparam int MAXC      = (MAXC_XY > CELLS_Z) ? MAXC_XY : CELLS_Z;
   localparam int QW        = $clog2(MAXC);
   localparam int SW        = (QW > 1) ? $clog2(QW) : 1;
   localparam int WW        = 36;
   localparam int TW        = 32;
   localparam int KW        = 40;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Configuration registers.
   logic signed [31:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic [23:0]        cell_size_ff, max_gap_ff;
   logic [19:0]        fill_threshold_ff, valid_threshold_ff;

   // Sequencer and working registers.
   state_type          state_ff, state_in;
   command_type        cmd_ff, cmd_in;
   logic signed [31:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic               g_ff, g_in;
   logic [1:0]         axis_ff, axis_in;
   logic [WW-1:0]      rem_ff, rem_in, dvs_ff, dvs_in, prod_ff, prod_in;
   logic [QW-1:0]      q_ff, q_in;
   logic [SW-1:0]      step_ff, step_in;
   logic [QW-1:0]      idx_ff [3];
   logic [QW-1:0]      idx_in [3];
   logic [1:0]         out_ff, out_in;
   logic               sat_ff, sat_in, keep_ff, keep_in;
   logic [CW-1:0]      cell_addr_ff [2];
   logic [CW-1:0]      cell_addr_in [2];
   logic [LW-1:0]      col_addr_ff [2];
   logic [LW-1:0]      col_addr_in [2];
   logic [CW-1:0]      clr_addr_ff, clr_addr_in;
   logic               clr_reply_ff, clr_reply_in;
   logic [LW-1:0]      bcol_ff, bcol_in;
   logic [ZW-1:0]      bz_ff, bz_in, proc_z_ff, proc_z_in;
   logic               bph_ff, bph_in, biss_ff, biss_in, pv_ff, pv_in, pph_ff, pph_in;
   logic [ZW-1:0]      safez_ff [2];
   logic [ZW-1:0]      safez_in [2];
   logic [WW-1:0]      gap_ff [2];
   logic [WW-1:0]      gap_in [2];
   logic               rsp_valid_ff, rsp_valid_in, rsp_keep_ff, rsp_keep_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   // Memories and their ports.
   logic [COUNT_BITS-1:0] cnt_plain_mem [NUM_CELLS];
   logic [COUNT_BITS-1:0] cnt_shift_mem [NUM_CELLS];
   logic [ZW-1:0]         lvl_plain_mem [NUM_COLS];
   logic [ZW-1:0]         lvl_shift_mem [NUM_COLS];
   logic [COUNT_BITS-1:0] cnt_rd_ff [2];
   logic [ZW-1:0]         lvl_rd_ff [2];
   logic [CW-1:0]         cnt_rd_addr [2];
   logic [CW-1:0]         cnt_wr_addr [2];
   logic [COUNT_BITS-1:0] cnt_wr_data [2];
   logic [1:0]            cnt_we;
   logic [LW-1:0]         lvl_rd_addr [2];
   logic [LW-1:0]         lvl_wr_addr;
   logic [ZW-1:0]         lvl_wr_data [2];
   logic                  lvl_we;

   // Combinational helpers.
   logic [23:0]           cs_e;
   logic signed [31:0]    p_sel, o_sel;
   logic signed [WW-1:0]  d_val;
   logic [WW-1:0]         lim, diff;
   logic [QW-1:0]         q_next;
   logic [31:0]           cells_axis, col32, cell32, baddr32;
   logic signed [KW-1:0]  top, pz2;
   logic                  axis_done;
   logic [1:0]            last_axis;

   assign cs_e      = (cell_size_ff == 24'd0) ? 24'd1 : cell_size_ff;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_keep   = rsp_keep_ff;
   assign rsp_status = rsp_status_ff;

   // Axis operand selection and the distance from the grid origin in half millimetres.
   always_comb begin
      case (axis_ff)
         2'd0: begin
            p_sel = px_ff;
            o_sel = origin_x_ff;
            cells_axis = 32'(CELLS_X);
         end
         2'd1: begin
            p_sel = py_ff;
            o_sel = origin_y_ff;
            cells_axis = 32'(CELLS_Y);
         end
         default: begin
            p_sel = pz_ff;
            o_sel = origin_z_ff;
            cells_axis = 32'(CELLS_Z);
         end
      endcase
      d_val = (WW'(p_sel) <<< 1) - (WW'(o_sel) <<< 1)
            + (g_ff ? signed'(WW'(cs_e)) : signed'(WW'(0)));
      lim   = WW'(cs_e) << (QW + 1);
      diff  = rem_ff - dvs_ff;
      q_next = QW'({q_ff, ~diff[WW-1]});
      col32  = 32'(idx_ff[0]) * 32'(CELLS_Y) + 32'(idx_ff[1]);
      cell32 = col32 * 32'(CELLS_Z) + 32'(idx_ff[2]);
      baddr32 = 32'(bcol_ff) * 32'(CELLS_Z) + 32'(bz_ff);
      top = (KW'(origin_z_ff) <<< 1)
          - (g_ff ? signed'(KW'(cs_e)) : signed'(KW'(0)))
          + signed'(KW'(prod_ff));
      pz2 = KW'(pz_ff) <<< 1;
      last_axis = (cmd_ff == CMD_ADD) ? 2'd2 : 2'd1;
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      px_in = px_ff;
      py_in = py_ff;
      pz_in = pz_ff;
      g_in = g_ff;
      axis_in = axis_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      prod_in = prod_ff;
      q_in = q_ff;
      step_in = step_ff;
      idx_in = idx_ff;
      out_in = out_ff;
      sat_in = sat_ff;
      keep_in = keep_ff;
      cell_addr_in = cell_addr_ff;
      col_addr_in = col_addr_ff;
      clr_addr_in = clr_addr_ff;
      clr_reply_in = clr_reply_ff;
      bcol_in = bcol_ff;
      bz_in = bz_ff;
      bph_in = bph_ff;
      biss_in = biss_ff;
      pv_in = 1'b0;
      proc_z_in = proc_z_ff;
      pph_in = pph_ff;
      safez_in = safez_ff;
      gap_in = gap_ff;
      rsp_keep_in = rsp_keep_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      axis_done = 1'b0;
      cnt_we = 2'b00;
      lvl_we = 1'b0;
      for (int i = 0; i < 2; i++) begin
         cnt_rd_addr[i] = CW'(baddr32);
         cnt_wr_addr[i] = clr_addr_ff;
         cnt_wr_data[i] = '0;
         lvl_rd_addr[i] = col_addr_ff[i];
         lvl_wr_data[i] = '0;
      end
      lvl_wr_addr = LW'(clr_addr_ff);

      case (state_ff)
         // Zero one entry of each count store per cycle, and of each level store until it is all zero.
         ST_CLEAR: begin
            cnt_we = 2'b11;
            if (32'(clr_addr_ff) < 32'(NUM_COLS)) begin
               lvl_we = 1'b1;
            end
            if (clr_addr_ff == CW'(NUM_CELLS - 1)) begin
               state_in = clr_reply_ff ? ST_FINISH : ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               cmd_in = command_type'(req_command);
               px_in = req_point_x;
               py_in = req_point_y;
               pz_in = req_point_z;
               out_in = 2'b00;
               sat_in = 1'b0;
               keep_in = 1'b0;
               g_in = 1'b0;
               axis_in = 2'd0;
               case (command_type'(req_command))
                  CMD_CLEAR: begin
                     clr_addr_in = '0;
                     clr_reply_in = 1'b1;
                     state_in = ST_CLEAR;
                  end
                  CMD_BUILD: begin
                     bcol_in = '0;
                     bz_in = '0;
                     bph_in = 1'b0;
                     biss_in = 1'b1;
                     state_in = ST_BUILD;
                  end
                  default: begin
                     state_in = ST_LOAD;
                  end
               endcase
            end
         end

         // Range check and divider setup for one axis.
         ST_LOAD: begin
            if (d_val[WW-1] || ($unsigned(d_val) >= lim)) begin
               out_in[g_ff] = 1'b1;
               axis_done = 1'b1;
            end else begin
               rem_in = $unsigned(d_val);
               dvs_in = WW'(cs_e) << QW;
               q_in = '0;
               step_in = SW'(QW - 1);
               state_in = ST_DIV;
            end
         end

         // One quotient bit per cycle.
         ST_DIV: begin
            if (!diff[WW-1]) begin
               rem_in = diff;
            end
            q_in = q_next;
            dvs_in = dvs_ff >> 1;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               axis_done = 1'b1;
               idx_in[axis_ff] = q_next;
               if (32'(q_next) >= cells_axis) begin
                  out_in[g_ff] = 1'b1;
               end
            end
         end

         // Linear cell and column addresses of the located grid.
         ST_ADDR: begin
            cell_addr_in[g_ff] = CW'(cell32);
            col_addr_in[g_ff] = LW'(col32);
            if (!g_ff) begin
               g_in = 1'b1;
               axis_in = 2'd0;
               state_in = ST_LOAD;
            end else if (cmd_ff == CMD_ADD) begin
               state_in = ST_ADD_RD;
            end else begin
               state_in = ST_CLS_RD;
            end
         end

         ST_ADD_RD: begin
            cnt_rd_addr[0] = cell_addr_ff[0];
            cnt_rd_addr[1] = cell_addr_ff[1];
            state_in = ST_ADD_WR;
         end

         // Saturating increment in the grids that contain the point.
         ST_ADD_WR: begin
            for (int i = 0; i < 2; i++) begin
               cnt_wr_addr[i] = cell_addr_ff[i];
               cnt_wr_data[i] = cnt_rd_ff[i] + 1'b1;
               if (!out_ff[i]) begin
                  if (cnt_rd_ff[i] == COUNT_MAX) begin
                     sat_in = 1'b1;
                  end else begin
                     cnt_we[i] = 1'b1;
                  end
               end
            end
            state_in = ST_FINISH;
         end

         ST_CLS_RD: begin
            g_in = 1'b0;
            state_in = ST_CLS_MUL;
         end

         // Height of the top of the safe cell above the grid floor.
         ST_CLS_MUL: begin
            prod_in = WW'({1'b0, lvl_rd_ff[g_ff]} + 1'b1) * WW'({cs_e, 1'b0});
            state_in = ST_CLS_CMP;
         end

         ST_CLS_CMP: begin
            if (!out_ff[g_ff] && (pz2 <= top)) begin
               keep_in = 1'b1;
            end
            if (!g_ff) begin
               g_in = 1'b1;
               state_in = ST_CLS_MUL;
            end else begin
               state_in = ST_FINISH;
            end
         end

         // Two read passes per column, both grids side by side.
         ST_BUILD: begin
            pv_in = biss_ff;
            proc_z_in = bz_ff;
            pph_in = bph_ff;
            if (biss_ff) begin
               if (bz_ff == ZW'(CELLS_Z - 1)) begin
                  bz_in = '0;
                  bph_in = ~bph_ff;
                  if (bph_ff) begin
                     biss_in = 1'b0;
                  end
               end else begin
                  bz_in = bz_ff + 1'b1;
               end
            end
            if (pv_ff) begin
               for (int i = 0; i < 2; i++) begin
                  if (!pph_ff) begin
                     // Highest valid cell.
                     if (TW'(cnt_rd_ff[i]) >= TW'(valid_threshold_ff)) begin
                        safez_in[i] = proc_z_ff;
                     end else if (proc_z_ff == '0) begin
                        safez_in[i] = '0;
                     end
                  end else begin
                     // Climb through filled cells within the gap.
                     if (proc_z_ff <= safez_ff[i]) begin
                        gap_in[i] = WW'(cs_e);
                     end else if ((gap_ff[i] < WW'(max_gap_ff)) &&
                                  (TW'(cnt_rd_ff[i]) >= TW'(fill_threshold_ff))) begin
                        safez_in[i] = proc_z_ff;
                        gap_in[i] = WW'(cs_e);
                     end else begin
                        gap_in[i] = gap_ff[i] + WW'(cs_e);
                     end
                  end
               end
               if (pph_ff && (proc_z_ff == ZW'(CELLS_Z - 1))) begin
                  state_in = ST_BWRITE;
               end
            end
         end

         ST_BWRITE: begin
            lvl_we = 1'b1;
            lvl_wr_addr = bcol_ff;
            lvl_wr_data[0] = safez_ff[0];
            lvl_wr_data[1] = safez_ff[1];
            if (bcol_ff == LW'(NUM_COLS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               bcol_in = bcol_ff + 1'b1;
               bz_in = '0;
               bph_in = 1'b0;
               biss_in = 1'b1;
               state_in = ST_BUILD;
            end
         end

         // Hand the response over once the output register is free.
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_keep_in = (cmd_ff == CMD_CLASSIFY) && keep_ff;
               case (cmd_ff)
                  CMD_ADD: begin
                     rsp_status_in = (out_ff != 2'b00) ? STATUS_OUTSIDE :
                                     (sat_ff ? STATUS_SAT : STATUS_DONE);
                  end
                  CMD_CLASSIFY: begin
                     rsp_status_in = (out_ff != 2'b00) ? STATUS_OUTSIDE : STATUS_DONE;
                  end
                  default: begin
                     rsp_status_in = STATUS_DONE;
                  end
               endcase
               clr_reply_in = 1'b0;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Step to the next axis or on to address generation.
      if (axis_done) begin
         if (axis_ff == last_axis) begin
            state_in = ST_ADDR;
         end else begin
            axis_in = axis_ff + 1'b1;
            state_in = ST_LOAD;
         end
      end
   end

   // Control registers and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_addr_ff <= '0;
         clr_reply_ff <= 1'b0;
         biss_ff <= 1'b0;
         pv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         origin_z_ff <= '0;
         cell_size_ff <= RESET_CELL_SIZE;
         fill_threshold_ff <= RESET_FILL_THRESHOLD;
         valid_threshold_ff <= RESET_VALID_THRESHOLD;
         max_gap_ff <= RESET_MAX_GAP;
      end else begin
         state_ff <= state_in;
         clr_addr_ff <= clr_addr_in;
         clr_reply_ff <= clr_reply_in;
         biss_ff <= biss_in;
         pv_ff <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ORIGIN_X: origin_x_ff <= csr_wr_data;
               CSR_ORIGIN_Y: origin_y_ff <= csr_wr_data;
               CSR_ORIGIN_Z: origin_z_ff <= csr_wr_data;
               CSR_CELL_SIZE: cell_size_ff <= csr_wr_data[23:0];
               CSR_FILL_THRESHOLD: fill_threshold_ff <= csr_wr_data[19:0];
               CSR_VALID_THRESHOLD: valid_threshold_ff <= csr_wr_data[19:0];
               CSR_MAX_GAP: max_gap_ff <= csr_wr_data[23:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      px_ff <= px_in;
      py_ff <= py_in;
      pz_ff <= pz_in;
      g_ff <= g_in;
      axis_ff <= axis_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      prod_ff <= prod_in;
      q_ff <= q_in;
      step_ff <= step_in;
      idx_ff <= idx_in;
      out_ff <= out_in;
      sat_ff <= sat_in;
      keep_ff <= keep_in;
      cell_addr_ff <= cell_addr_in;
      col_addr_ff <= col_addr_in;
      bcol_ff <= bcol_in;
      bz_ff <= bz_in;
      bph_ff <= bph_in;
      proc_z_ff <= proc_z_in;
      pph_ff <= pph_in;
      safez_ff <= safez_in;
      gap_ff <= gap_in;
      rsp_keep_ff <= rsp_keep_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Count memories, one per grid.
   always_ff @(posedge clock) begin
      if (cnt_we[0]) begin
         cnt_plain_mem[cnt_wr_addr[0]] <= cnt_wr_data[0];
      end
      cnt_rd_ff[0] <= cnt_plain_mem[cnt_rd_addr[0]];
   end

   always_ff @(posedge clock) begin
      if (cnt_we[1]) begin
         cnt_shift_mem[cnt_wr_addr[1]] <= cnt_wr_data[1];
      end
      cnt_rd_ff[1] <= cnt_shift_mem[cnt_rd_addr[1]];
   end

   // Safe level memories, one per grid.
   always_ff @(posedge clock) begin
      if (lvl_we) begin
         lvl_plain_mem[lvl_wr_addr] <= lvl_wr_data[0];
      end
      lvl_rd_ff[0] <= lvl_plain_mem[lvl_rd_addr[0]];
   end

   always_ff @(posedge clock) begin
      if (lvl_we) begin
         lvl_shift_mem[lvl_wr_addr] <= lvl_wr_data[1];
      end
      lvl_rd_ff[1] <= lvl_shift_mem[lvl_rd_addr[1]];
   end

`ifndef SYNTHESIS
   // The partial remainder stays below twice the shifted divisor.
   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < (dvs_ff << 1)))
      else $error("divider remainder out of range");

   // Saturation is reported only on add, which never keeps.
   a_sat_no_keep: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_SAT)) |-> !rsp_keep_ff)
      else $error("saturated response with keep set");

   // An accepted request always leaves the idle state.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("request accepted without starting work");
`endif

endmodule

`default_nettype wire

/* tb/tb_voxel_column_upper_noise_filter_unit.sv */
// Self-checking testbench of the voxel column upper noise filter unit.
`default_nettype none

module tb_voxel_column_upper_noise_filter_unit;
   import vcunf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NX = 32;
   localparam int NY = 32;
   localparam int NZ = 32;
   localparam int NCOLS = NX * NY;
   localparam int NCELLS = NCOLS * NZ;
   localparam logic [19:0] COUNT_FULL = 20'hFFFFF;
   localparam longint CYCLE_LIMIT = 8000000;

   typedef struct {
      command_type      cmd;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } point_request_type;

   typedef struct {
      logic       keep;
      logic [1:0] status;
   } filter_answer_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [2:0] csr_index;
   logic [31:0] csr_wr_data;
   logic req_valid;
   logic req_stall;
   logic [1:0] req_command;
   logic signed [31:0] req_point_x;
   logic signed [31:0] req_point_y;
   logic signed [31:0] req_point_z;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_keep;
   logic [1:0] rsp_status;

   voxel_column_upper_noise_filter_unit u_top (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_point_x(req_point_x), .req_point_y(req_point_y), .req_point_z(req_point_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_keep(rsp_keep), .rsp_status(rsp_status)
   );

   // Shadow copy of the registers and stores.
   longint org_x, org_y, org_z;
   logic [23:0] cell_edge;
   logic [19:0] fill_min, valid_min;
   logic [23:0] gap_limit;
   logic [19:0] plain_counts[NCELLS];
   logic [19:0] shifted_counts[NCELLS];
   logic [4:0] plain_levels[NCOLS];
   logic [4:0] shifted_levels[NCOLS];

   point_request_type pending_requests[$];
   filter_answer_type expected_answers[$];
   int mismatches = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   logic hold_on = 1'b0;
   logic pressure_go = 1'b0;
   longint cycle_count = 0;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint eff_edge();
      return (cell_edge == 24'd0) ? 64'sd1 : longint'(cell_edge);
   endfunction

   // Axis index in the plain (g = 0) or half-cell shifted (g = 1) grid.
   function automatic bit axis_cell(int g, longint p, longint org, int cells,
                                    output int idx);
      longint cs;
      longint d;
      longint q;
      cs = eff_edge();
      d = 2 * p - (2 * org - (g ? cs : 0));
      idx = 0;
      if (d < 0) return 1'b0;
      q = d / (2 * cs);
      if (q >= cells) return 1'b0;
      idx = int'(q);
      return 1'b1;
   endfunction

   function automatic void wipe_stores();
      for (int i = 0; i < NCELLS; i++) begin
         plain_counts[i] = '0;
         shifted_counts[i] = '0;
      end
      for (int i = 0; i < NCOLS; i++) begin
         plain_levels[i] = '0;
         shifted_levels[i] = '0;
      end
   endfunction

   // Safe level of every column of one grid.
   function automatic void build_levels(int g);
      int safez;
      logic [19:0] c;
      longint cs;
      cs = eff_edge();
      for (int col = 0; col < NCOLS; col++) begin
         safez = 0;
         for (int z = 0; z < NZ; z++) begin
            c = g ? shifted_counts[col * NZ + z] : plain_counts[col * NZ + z];
            if (c >= valid_min) safez = z;
         end
         for (int z = safez + 1; z < NZ; z++) begin
            c = g ? shifted_counts[col * NZ + z] : plain_counts[col * NZ + z];
            if (longint'(z - safez) * cs < longint'(gap_limit) && c >= fill_min)
               safez = z;
         end
         if (g) shifted_levels[col] = 5'(safez);
         else plain_levels[col] = 5'(safez);
      end
   endfunction

   // Applies one request to the shadow stores and returns its answer.
   function automatic filter_answer_type filter_answer(point_request_type r);
      filter_answer_type a;
      bit outside;
      bit sat;
      int ix, iy, iz, addr, lv;
      longint cs, top2;
      a.keep = 1'b0;
      outside = 1'b0;
      sat = 1'b0;
      cs = eff_edge();
      case (r.cmd)
         CMD_CLEAR: wipe_stores();
         CMD_ADD: begin
            for (int g = 0; g < 2; g++) begin
               if (!axis_cell(g, r.x, org_x, NX, ix) || !axis_cell(g, r.y, org_y, NY, iy) ||
                   !axis_cell(g, r.z, org_z, NZ, iz)) begin
                  outside = 1'b1;
               end else begin
                  addr = (ix * NY + iy) * NZ + iz;
                  if (g) begin
                     if (shifted_counts[addr] == COUNT_FULL) sat = 1'b1;
                     else shifted_counts[addr]++;
                  end else begin
                     if (plain_counts[addr] == COUNT_FULL) sat = 1'b1;
                     else plain_counts[addr]++;
                  end
               end
            end
         end
         CMD_BUILD: begin
            build_levels(0);
            build_levels(1);
         end
         default: begin
            for (int g = 0; g < 2; g++) begin
               if (!axis_cell(g, r.x, org_x, NX, ix) || !axis_cell(g, r.y, org_y, NY, iy)) begin
                  outside = 1'b1;
               end else begin
                  lv = g ? shifted_levels[ix * NY + iy] : plain_levels[ix * NY + iy];
                  top2 = 2 * org_z - (g ? cs : 0) + longint'(lv + 1) * 2 * cs;
                  if (2 * longint'(r.z) <= top2) a.keep = 1'b1;
               end
            end
         end
      endcase
      a.status = outside ? STATUS_OUTSIDE : (sat ? STATUS_SAT : STATUS_DONE);
      return a;
   endfunction

   task automatic flag_mismatch(string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatches++;
   endtask

   // Request driver: predicts each accepted request, then offers the next one.
   always @(posedge clock) begin
      point_request_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_answers.push_back(filter_answer('{command_type'(req_command),
               req_point_x, req_point_y, req_point_z}));
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_command <= nxt.cmd;
               req_point_x <= nxt.x;
               req_point_y <= nxt.y;
               req_point_z <= nxt.z;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compares each accepted response with the oldest answer.
   always @(posedge clock) begin
      filter_answer_type exp_a;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_answers.size() == 0) begin
               flag_mismatch("response with no request outstanding");
            end else begin
               exp_a = expected_answers.pop_front();
               if (rsp_keep !== exp_a.keep)
                  flag_mismatch($sformatf("keep %b, expected %b", rsp_keep, exp_a.keep));
               if (rsp_status !== exp_a.status)
                  flag_mismatch($sformatf("status %0d, expected %0d", rsp_status, exp_a.status));
            end
         end
         rsp_stall <= hold_on || ($urandom_range(99) < stall_pct);
      end
   end

   // Long receiver hold-off so the block backs up into its input.
   initial begin
      while (!pressure_go) @(posedge clock);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (600) @(posedge clock);
      hold_on <= 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Register write; the shadow copy follows.
   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      case (idx)
         CSR_ORIGIN_X: org_x = longint'($signed(val));
         CSR_ORIGIN_Y: org_y = longint'($signed(val));
         CSR_ORIGIN_Z: org_z = longint'($signed(val));
         CSR_CELL_SIZE: cell_edge = val[23:0];
         CSR_FILL_THRESHOLD: fill_min = val[19:0];
         CSR_VALID_THRESHOLD: valid_min = val[19:0];
         CSR_MAX_GAP: gap_limit = val[23:0];
         default: ;
      endcase
   endtask

   task automatic set_regs(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [31:0] cs, logic [31:0] fill, logic [31:0] valid,
                           logic [31:0] gap);
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_ORIGIN_Z, oz);
      write_reg(CSR_CELL_SIZE, cs);
      write_reg(CSR_FILL_THRESHOLD, fill);
      write_reg(CSR_VALID_THRESHOLD, valid);
      write_reg(CSR_MAX_GAP, gap);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic push_req(command_type c, longint x, longint y, longint z);
      point_request_type r;
      r.cmd = c;
      r.x = x[31:0];
      r.y = y[31:0];
      r.z = z[31:0];
      pending_requests.push_back(r);
   endtask

   task automatic drain();
      while (pending_requests.size() > 0 || req_valid || expected_answers.size() > 0)
         @(posedge clock);
   endtask

   // Coordinate inside or just around a chosen cell span of one axis.
   function automatic longint near_coord(longint org, int lo_cell, int hi_cell);
      longint cs;
      cs = eff_edge();
      return org + (longint'($urandom_range(hi_cell - lo_cell)) + lo_cell) * cs
             + longint'($urandom_range(32'(cs - 1), 0));
   endfunction

   // Random requests: mostly adds packed into a few columns, mixed with classifies, with a build halfway.
   task automatic random_phase(int n, bit with_clear);
      int r;
      if (with_clear) push_req(CMD_CLEAR, $urandom, $urandom, $urandom);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (i == n / 2) push_req(CMD_BUILD, $urandom, $urandom, $urandom);
         if (r < 6)
            push_req(command_type'($urandom_range(3, 1) == 2 ? CMD_ADD : CMD_CLASSIFY),
                     $signed($urandom), $signed($urandom), $signed($urandom));
         else if (r < 62)
            push_req(CMD_ADD, near_coord(org_x, 0, 2), near_coord(org_y, 0, 2),
                     near_coord(org_z, 0, ($urandom_range(3) == 0) ? 31 : 6));
         else
            push_req(CMD_CLASSIFY, near_coord(org_x, -1, 3), near_coord(org_y, -1, 3),
                     near_coord(org_z, -2, 33));
      end
      drain();
   endtask

   // Main sequence.
   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_ORIGIN_X;
      csr_wr_data = '0;
      req_valid = 1'b0;
      req_command = CMD_CLEAR;
      req_point_x = '0;
      req_point_y = '0;
      req_point_z = '0;
      rsp_stall = 1'b0;
      org_x = 0;
      org_y = 0;
      org_z = 0;
      cell_edge = RESET_CELL_SIZE;
      fill_min = RESET_FILL_THRESHOLD;
      valid_min = RESET_VALID_THRESHOLD;
      gap_limit = RESET_MAX_GAP;
      wipe_stores();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part at reset settings: classify before any build, edges, extremes.
      push_req(CMD_CLASSIFY, 100, 100, 5000);
      push_req(CMD_CLASSIFY, 100, 100, 5001);
      push_req(CMD_CLASSIFY, -1, 0, 0);
      push_req(CMD_ADD, 0, 0, 0);
      push_req(CMD_ADD, -1, 0, 0);
      push_req(CMD_ADD, -2500, -2500, -2500);
      push_req(CMD_ADD, 159999, 159999, 159999);
      push_req(CMD_ADD, 160000, 0, 0);
      push_req(CMD_ADD, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      push_req(CMD_ADD, -32'sh80000000, -32'sh80000000, -32'sh80000000);
      for (int i = 0; i < 5; i++) push_req(CMD_ADD, 10, 10, 2600 + 5000 * (i % 2));
      push_req(CMD_ADD, 10, 10, 25000);
      push_req(CMD_BUILD, 0, 0, 0);
      push_req(CMD_CLASSIFY, 10, 10, 10000);
      push_req(CMD_CLASSIFY, 10, 10, 30001);
      push_req(CMD_CLASSIFY, 157500, 10, 0);
      push_req(CMD_CLASSIFY, -32'sh80000000, 32'sh7FFFFFFF, 0);
      push_req(CMD_CLEAR, 0, 0, 0);
      push_req(CMD_CLASSIFY, 10, 10, 10000);
      drain();
      // An index beyond the register list is ignored.
      write_reg(3'd7, 32'hFFFFFFFF);

      set_regs(-1000, 2000, -500, 100, 1, 3, 250);
      random_phase(220, 1'b0);

      send_idle_pct = 60;
      set_regs($urandom, $urandom, $urandom, 1, 2, 2, 3);
      random_phase(210, 1'b1);

      send_idle_pct = 0;
      stall_pct = 60;
      set_regs(32'h80000000, 32'h7FFFFFFF, -20000, 32'hFF989680, 1, 1000000, 10000000);
      random_phase(200, 1'b0);

      send_idle_pct = 32;
      stall_pct = 32;
      set_regs(-40, 40, 7, 0, 1, 1, 0);
      random_phase(220, 1'b1);

      // Backpressure: the receiver holds off while requests keep coming.
      send_idle_pct = 0;
      stall_pct = 0;
      set_regs(0, 0, 0, 5000, 32'hFFF00002, 32'hFFFFF, 5000);
      pressure_go <= 1'b1;
      random_phase(200, 1'b0);

      send_idle_pct = 32;
      stall_pct = 32;
      set_regs(-123456, 987654, -3000, 7, 1, 4, 10000000);
      random_phase(220, 1'b1);

      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire
